// File: hdl/pidaw_pkg.sv
package pidaw_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int TIME_W        = 32;
    localparam int PERIOD_W      = 16;
    localparam int PERIOD_RESET  = 10;

    // scaled product terms saturate at +-2^60, so 62 signed bits hold them
    localparam int TERM_W        = 62;
    localparam int TERM_MAX_BIT  = 60;

    localparam int REG_IDX_W     = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_LIMIT_LO = 3'd3,
        REG_LIMIT_HI = 3'd4,
        REG_PERIOD   = 3'd5,
        REG_SETPOINT = 3'd6
    } reg_idx_t;

endpackage

// File: hdl/pidaw_if.sv
interface pidaw_sample_if #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF
);
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic signed [DATA_WIDTH-1:0]       measured;
    logic signed [DATA_WIDTH-1:0]       goal;
    logic                               goal_present;
    logic [pidaw_pkg::TIME_W-1:0]       now_ms;

    modport source (
        output valid, func, measured, goal, goal_present, now_ms,
        input  ready
    );
    modport sink (
        input  valid, func, measured, goal, goal_present, now_ms,
        output ready
    );
endinterface

interface pidaw_result_if #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive;

    modport source (
        output valid, drive,
        input  ready
    );
    modport sink (
        input  valid, drive,
        output ready
    );
endinterface

// File: hdl/pid_controller_antiwindup.sv
// PID controller, derivative on measurement, integral clamped against windup.
//
// sample channel: one item per control step (func, measured, goal,
//   goal_present, now_ms). func = 0 computes at once; func = 1 computes only
//   when at least period_ms have passed since the last gated computation,
//   otherwise the item is dropped with no result and no state change.
// result channel: one drive item per computed step, clamped to the limits.
// APB port: seven registers at 4-byte stride (8-byte stride when DATA_WIDTH
//   exceeds 32), pready tied high. Write registers only while idle.
//
// Path: an accepted item goes into the input register, then through a single pass
//   of three multipliers and two clamps into the result register. Throughput:
//   1 item per cycle while no result is waiting on a stalled receiver; the
//   critical path is the multiply, integral add/clamp and drive add/clamp in
//   that one pass.
// Stall: a waiting result holds; one more item sits in the input register,
//   and sample.ready drops only while both are occupied.
// Reset: integral, prior measurement and last sample time clear to zero,
//   registers return to their defaults, both stages empty.
module pid_controller_antiwindup #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [((DATA_WIDTH > 32) ? 6 : 5)-1:0]   paddr,
    input  logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                                     pready,
    pidaw_sample_if.sink                             sample,
    pidaw_result_if.source                           result
);

    // register map: stride follows the widest register
    localparam int PDATA_W  = (DATA_WIDTH > 32) ? 64 : 32;
    localparam int ADDR_LSB = (DATA_WIDTH > 32) ? 3 : 2;
    localparam int ADDR_W   = ADDR_LSB + pidaw_pkg::REG_IDX_W;

    logic signed [DATA_WIDTH-1:0]   gain_p;
    logic signed [DATA_WIDTH-1:0]   gain_i_scaled;
    logic signed [DATA_WIDTH-1:0]   gain_d_scaled;
    logic signed [DATA_WIDTH-1:0]   limit_low;
    logic signed [DATA_WIDTH-1:0]   limit_high;
    logic [pidaw_pkg::PERIOD_W-1:0] period_ms;
    logic signed [DATA_WIDTH-1:0]   setpoint;

    pidaw_regs #(
        .DATA_WIDTH (DATA_WIDTH),
        .PDATA_W    (PDATA_W),
        .ADDR_LSB   (ADDR_LSB),
        .ADDR_W     (ADDR_W)
    ) u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .gain_p        (gain_p),
        .gain_i_scaled (gain_i_scaled),
        .gain_d_scaled (gain_d_scaled),
        .limit_low     (limit_low),
        .limit_high    (limit_high),
        .period_ms     (period_ms),
        .setpoint      (setpoint)
    );

    // input register, controller state and result register live here
    pidaw_core #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .gain_p        (gain_p),
        .gain_i_scaled (gain_i_scaled),
        .gain_d_scaled (gain_d_scaled),
        .limit_low     (limit_low),
        .limit_high    (limit_high),
        .period_ms     (period_ms),
        .setpoint      (setpoint),
        .sample        (sample),
        .result        (result)
    );

endmodule

// File: hdl/pidaw_regs.sv
module pidaw_regs #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
    parameter int PDATA_W    = 32,
    parameter int ADDR_LSB   = 2,
    parameter int ADDR_W     = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ADDR_W-1:0]                    paddr,
    input  logic [PDATA_W-1:0]                   pwdata,
    output logic [PDATA_W-1:0]                   prdata,
    output logic                                 pready,
    output logic signed [DATA_WIDTH-1:0]         gain_p,
    output logic signed [DATA_WIDTH-1:0]         gain_i_scaled,
    output logic signed [DATA_WIDTH-1:0]         gain_d_scaled,
    output logic signed [DATA_WIDTH-1:0]         limit_low,
    output logic signed [DATA_WIDTH-1:0]         limit_high,
    output logic [pidaw_pkg::PERIOD_W-1:0]       period_ms,
    output logic signed [DATA_WIDTH-1:0]         setpoint
);

    logic signed [DATA_WIDTH-1:0]   gain_p_reg;
    logic signed [DATA_WIDTH-1:0]   gain_i_reg;
    logic signed [DATA_WIDTH-1:0]   gain_d_reg;
    logic signed [DATA_WIDTH-1:0]   limit_low_reg;
    logic signed [DATA_WIDTH-1:0]   limit_high_reg;
    logic [pidaw_pkg::PERIOD_W-1:0] period_reg;
    logic signed [DATA_WIDTH-1:0]   setpoint_reg;

    pidaw_pkg::reg_idx_t            idx;
    logic                           wr_en;
    logic [PDATA_W-1:0]             prdata_next;

    assign idx    = pidaw_pkg::reg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            limit_low_reg  <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
            limit_high_reg <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
            period_reg     <= pidaw_pkg::PERIOD_W'(pidaw_pkg::PERIOD_RESET);
            setpoint_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                pidaw_pkg::REG_GAIN_P:   gain_p_reg     <= pwdata[DATA_WIDTH-1:0];
                pidaw_pkg::REG_GAIN_I:   gain_i_reg     <= pwdata[DATA_WIDTH-1:0];
                pidaw_pkg::REG_GAIN_D:   gain_d_reg     <= pwdata[DATA_WIDTH-1:0];
                pidaw_pkg::REG_LIMIT_LO: limit_low_reg  <= pwdata[DATA_WIDTH-1:0];
                pidaw_pkg::REG_LIMIT_HI: limit_high_reg <= pwdata[DATA_WIDTH-1:0];
                pidaw_pkg::REG_PERIOD:   period_reg     <= pwdata[pidaw_pkg::PERIOD_W-1:0];
                pidaw_pkg::REG_SETPOINT: setpoint_reg   <= pwdata[DATA_WIDTH-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        prdata_next = '0;
        unique case (idx)
            pidaw_pkg::REG_GAIN_P:   prdata_next[DATA_WIDTH-1:0] = gain_p_reg;
            pidaw_pkg::REG_GAIN_I:   prdata_next[DATA_WIDTH-1:0] = gain_i_reg;
            pidaw_pkg::REG_GAIN_D:   prdata_next[DATA_WIDTH-1:0] = gain_d_reg;
            pidaw_pkg::REG_LIMIT_LO: prdata_next[DATA_WIDTH-1:0] = limit_low_reg;
            pidaw_pkg::REG_LIMIT_HI: prdata_next[DATA_WIDTH-1:0] = limit_high_reg;
            pidaw_pkg::REG_PERIOD:   prdata_next[pidaw_pkg::PERIOD_W-1:0] = period_reg;
            pidaw_pkg::REG_SETPOINT: prdata_next[DATA_WIDTH-1:0] = setpoint_reg;
            default:                 prdata_next = '0;
        endcase
    end

    assign prdata        = prdata_next;
    assign gain_p        = gain_p_reg;
    assign gain_i_scaled = gain_i_reg;
    assign gain_d_scaled = gain_d_reg;
    assign limit_low     = limit_low_reg;
    assign limit_high    = limit_high_reg;
    assign period_ms     = period_reg;
    assign setpoint      = setpoint_reg;

endmodule

// File: hdl/pidaw_qmul.sv
// Fixed-point product: floor(a*b / 2^FRAC_BITS), saturated to +-2^60.
module pidaw_qmul #(
    parameter int OP_W      = pidaw_pkg::DATA_WIDTH_DEF + 1,
    parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS_DEF
) (
    input  logic signed [OP_W-1:0]              a,
    input  logic signed [OP_W-1:0]              b,
    output logic signed [pidaw_pkg::TERM_W-1:0] term
);

    localparam int PROD_W = 2 * OP_W;
    localparam int EXT_W  = (PROD_W > pidaw_pkg::TERM_W + 1) ? PROD_W
                                                              : pidaw_pkg::TERM_W + 1;

    logic signed [PROD_W-1:0] prod;
    logic signed [EXT_W-1:0]  prod_ext;
    logic signed [EXT_W-1:0]  scaled;
    logic signed [EXT_W-1:0]  term_max;
    logic signed [EXT_W-1:0]  term_min;
    logic signed [EXT_W-1:0]  sat;

    assign prod     = PROD_W'(a) * PROD_W'(b);
    assign prod_ext = EXT_W'(prod);
    // arithmetic shift rounds toward minus infinity
    assign scaled   = prod_ext >>> FRAC_BITS;
    assign term_max = $signed({{(EXT_W-pidaw_pkg::TERM_MAX_BIT-1){1'b0}}, 1'b1,
                               {pidaw_pkg::TERM_MAX_BIT{1'b0}}});
    assign term_min = -term_max;

    always_comb
    begin
        if (scaled > term_max)
            sat = term_max;
        else if (scaled < term_min)
            sat = term_min;
        else
            sat = scaled;
    end

    assign term = sat[pidaw_pkg::TERM_W-1:0];

endmodule

// File: hdl/pidaw_core.sv
module pidaw_core #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [DATA_WIDTH-1:0]      gain_p,
    input  logic signed [DATA_WIDTH-1:0]      gain_i_scaled,
    input  logic signed [DATA_WIDTH-1:0]      gain_d_scaled,
    input  logic signed [DATA_WIDTH-1:0]      limit_low,
    input  logic signed [DATA_WIDTH-1:0]      limit_high,
    input  logic [pidaw_pkg::PERIOD_W-1:0]    period_ms,
    input  logic signed [DATA_WIDTH-1:0]      setpoint,
    pidaw_sample_if.sink                      sample,
    pidaw_result_if.source                    result
);

    localparam int OP_W   = DATA_WIDTH + 1;
    localparam int SUM_W  = pidaw_pkg::TERM_W + 2;
    localparam int TIME_W = pidaw_pkg::TIME_W;

    // input register
    logic                         s1_valid_reg, s1_valid_next;
    logic                         s1_func_reg;
    logic signed [DATA_WIDTH-1:0] s1_meas_reg;
    logic signed [DATA_WIDTH-1:0] s1_goal_reg;
    logic                         s1_goal_present_reg;
    logic [TIME_W-1:0]            s1_now_reg;

    // controller state
    logic signed [DATA_WIDTH-1:0] integral_reg;
    logic signed [DATA_WIDTH-1:0] prior_meas_reg;
    logic [TIME_W-1:0]            last_sample_reg;

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] drive_reg;

    logic                         in_acc;
    logic                         out_free;
    logic                         gate_ok;
    logic                         adv;
    logic                         fire;
    logic [TIME_W-1:0]            elapsed;
    logic signed [DATA_WIDTH-1:0] target;
    logic signed [OP_W-1:0]       err;
    logic signed [OP_W-1:0]       change;
    logic signed [OP_W-1:0]       gain_p_ext;
    logic signed [OP_W-1:0]       gain_i_ext;
    logic signed [OP_W-1:0]       gain_d_ext;
    logic signed [pidaw_pkg::TERM_W-1:0] term_p;
    logic signed [pidaw_pkg::TERM_W-1:0] term_i;
    logic signed [pidaw_pkg::TERM_W-1:0] term_d;
    logic signed [SUM_W-1:0]      int_sum;
    logic signed [DATA_WIDTH-1:0] integral_next;
    logic signed [SUM_W-1:0]      out_sum;
    logic signed [DATA_WIDTH-1:0] drive_next;

    // raise to lo first, then lower to hi: crossed limits give hi
    function automatic logic signed [DATA_WIDTH-1:0] clamp(
        input logic signed [SUM_W-1:0]      v,
        input logic signed [DATA_WIDTH-1:0] lo,
        input logic signed [DATA_WIDTH-1:0] hi
    );
        logic signed [SUM_W-1:0] t;
        t = v;
        if (t < SUM_W'(lo))
            t = SUM_W'(lo);
        if (t > SUM_W'(hi))
            t = SUM_W'(hi);
        return t[DATA_WIDTH-1:0];
    endfunction

    assign out_free = !out_valid_reg || result.ready;
    assign elapsed  = s1_now_reg - last_sample_reg;
    assign gate_ok  = !s1_func_reg || (elapsed >= TIME_W'(period_ms));
    // a gated-out item needs no room in the result register
    assign adv      = s1_valid_reg && (out_free || !gate_ok);
    assign fire     = adv && gate_ok;

    assign sample.ready = !s1_valid_reg || adv;
    assign in_acc       = sample.valid && sample.ready;

    assign target     = s1_goal_present_reg ? s1_goal_reg : setpoint;
    assign err        = OP_W'(target) - OP_W'(s1_meas_reg);
    assign change     = OP_W'(s1_meas_reg) - OP_W'(prior_meas_reg);
    assign gain_p_ext = OP_W'(gain_p);
    assign gain_i_ext = OP_W'(gain_i_scaled);
    assign gain_d_ext = OP_W'(gain_d_scaled);

    pidaw_qmul #(.OP_W(OP_W), .FRAC_BITS(FRAC_BITS)) u_mul_p
    (
        .a    (gain_p_ext),
        .b    (err),
        .term (term_p)
    );

    pidaw_qmul #(.OP_W(OP_W), .FRAC_BITS(FRAC_BITS)) u_mul_i
    (
        .a    (err),
        .b    (gain_i_ext),
        .term (term_i)
    );

    pidaw_qmul #(.OP_W(OP_W), .FRAC_BITS(FRAC_BITS)) u_mul_d
    (
        .a    (gain_d_ext),
        .b    (change),
        .term (term_d)
    );

    assign int_sum       = SUM_W'(integral_reg) + SUM_W'(term_i);
    assign integral_next = clamp(int_sum, limit_low, limit_high);
    assign out_sum       = SUM_W'(term_p) + SUM_W'(integral_next) - SUM_W'(term_d);
    assign drive_next    = clamp(out_sum, limit_low, limit_high);

    always_comb
    begin
        if (in_acc)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (fire)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            integral_reg    <= '0;
            prior_meas_reg  <= '0;
            last_sample_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                integral_reg   <= integral_next;
                prior_meas_reg <= s1_meas_reg;
                if (s1_func_reg)
                    last_sample_reg <= s1_now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_func_reg         <= sample.func;
            s1_meas_reg         <= sample.measured;
            s1_goal_reg         <= sample.goal;
            s1_goal_present_reg <= sample.goal_present;
            s1_now_reg          <= sample.now_ms;
        end
        if (fire)
            drive_reg <= drive_next;
    end

    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;

endmodule

// File: hdl/pidaw_checker.sv
module pidaw_checker #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  sample_valid,
    input logic                  sample_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input logic [DATA_WIDTH-1:0] result_drive
);

    // empty pipeline out of reset
    assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result valid during reset");

    // only a full result register with a stalled receiver blocks new items
    assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> (result_valid && !result_ready))
        else $error("sample blocked without a stalled result");

    // a fresh result comes from an item accepted through the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_valid && sample_ready, 2))
        else $error("result without matching item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_drive)))
        else $error("stalled result changed");

endmodule

bind pid_controller_antiwindup pidaw_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_drive (result.drive)
);

// File: tb/tb_pid_controller_antiwindup.sv
module tb_pid_controller_antiwindup;

    localparam int DW = pidaw_pkg::DATA_WIDTH_DEF;
    localparam int FB = pidaw_pkg::FRAC_BITS_DEF;

    // a result is taken from the result register after its item passes the input
    // register; a gated item that drops leaves no trace in the expected queue, so
    // let a few more cycles pass before idle work
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_CYCLES     = 64;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int IDLE_PCT        = 21;

    // func codes of the sample item
    localparam logic FUNC_NOW   = 1'b0;
    localparam logic FUNC_GATED = 1'b1;

    typedef logic signed [DW-1:0]  q_t;
    typedef logic signed [127:0]   wide_t;

    localparam q_t    Q_ONE    = q_t'(1 << FB);
    localparam q_t    Q_BIG    = q_t'(1000 << FB);
    localparam q_t    Q_MAX    = {1'b0, {(DW-1){1'b1}}};
    localparam q_t    Q_MIN    = {1'b1, {(DW-1){1'b0}}};
    localparam wide_t TERM_CAP = wide_t'(1) <<< pidaw_pkg::TERM_MAX_BIT;

    // Controller state and register copies; one expected drive per computed step.
    class pid_scoreboard;
        q_t                             gain_p, gain_i, gain_d, lim_lo, lim_hi, setpoint;
        logic [pidaw_pkg::PERIOD_W-1:0] period;
        q_t                             integral, prior_meas;
        logic [pidaw_pkg::TIME_W-1:0]   last_ms;
        q_t                             drive_q[$];
        int                             errors;

        function new();
            gain_p     = '0;
            gain_i     = '0;
            gain_d     = '0;
            lim_lo     = Q_MIN;
            lim_hi     = Q_MAX;
            period     = pidaw_pkg::PERIOD_W'(pidaw_pkg::PERIOD_RESET);
            setpoint   = '0;
            integral   = '0;
            prior_meas = '0;
            last_ms    = '0;
            errors     = 0;
        endfunction

        function void write_reg(pidaw_pkg::reg_idx_t idx, logic [31:0] value);
            case (idx)
                pidaw_pkg::REG_GAIN_P:   gain_p   = value;
                pidaw_pkg::REG_GAIN_I:   gain_i   = value;
                pidaw_pkg::REG_GAIN_D:   gain_d   = value;
                pidaw_pkg::REG_LIMIT_LO: lim_lo   = value;
                pidaw_pkg::REG_LIMIT_HI: lim_hi   = value;
                pidaw_pkg::REG_PERIOD:   period   = value[pidaw_pkg::PERIOD_W-1:0];
                pidaw_pkg::REG_SETPOINT: setpoint = value;
                default: ;
            endcase
        endfunction

        // floor(a*b / 2^FB), saturated to +-2^60
        function wide_t scaled_product(wide_t a, wide_t b);
            wide_t p;
            p = (a * b) >>> FB;
            if (p > TERM_CAP)
                p = TERM_CAP;
            else if (p < -TERM_CAP)
                p = -TERM_CAP;
            return p;
        endfunction

        // low first, then high: crossed limits end at the high limit
        function wide_t clamp_wide(wide_t v, wide_t lo, wide_t hi);
            if (v < lo)
                v = lo;
            if (v > hi)
                v = hi;
            return v;
        endfunction

        function void note_sample(logic func, q_t meas, q_t goal, logic goal_present,
                                  logic [pidaw_pkg::TIME_W-1:0] now);
            logic [pidaw_pkg::TIME_W-1:0] elapsed;
            q_t                           target;
            wide_t                        err, change, acc;
            if (func == FUNC_GATED)
            begin
                elapsed = now - last_ms;
                if (elapsed < {{(pidaw_pkg::TIME_W-pidaw_pkg::PERIOD_W){1'b0}}, period})
                    return;
                last_ms = now;
            end
            target   = goal_present ? goal : setpoint;
            err      = wide_t'(target) - wide_t'(meas);
            acc      = wide_t'(integral) + scaled_product(err, wide_t'(gain_i));
            acc      = clamp_wide(acc, wide_t'(lim_lo), wide_t'(lim_hi));
            integral = acc[DW-1:0];
            change     = wide_t'(meas) - wide_t'(prior_meas);
            prior_meas = meas;
            acc = scaled_product(wide_t'(gain_p), err) + wide_t'(integral)
                - scaled_product(wide_t'(gain_d), change);
            acc = clamp_wide(acc, wide_t'(lim_lo), wide_t'(lim_hi));
            drive_q.push_back(acc[DW-1:0]);
        endfunction

        function void check_drive(q_t got);
            q_t want;
            if (drive_q.size() == 0)
            begin
                $display("%0t: unexpected drive item, expected none, actual %0d", $time, got);
                errors++;
                return;
            end
            want = drive_q.pop_front();
            if (got !== want)
            begin
                $display("%0t: drive mismatch, expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // steady: no idling on either side; hold_req: ask the sink for a long hold-off
    bit          steady   = 1'b0;
    bit          hold_req = 1'b0;

    logic [pidaw_pkg::TIME_W-1:0] clock_ms;

    pid_scoreboard sb = new();

    pidaw_sample_if #(.DATA_WIDTH(DW)) smp ();
    pidaw_result_if #(.DATA_WIDTH(DW)) res ();

    pid_controller_antiwindup #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (smp),
        .result  (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop far beyond the slowest correct run
    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Both channels are observed at the rising edge; results are checked
    // before the sample of the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res.ready)
                sb.check_drive(res.drive);
            if (smp.valid && smp.ready)
                sb.note_sample(smp.func, smp.measured, smp.goal, smp.goal_present,
                               smp.now_ms);
        end
    end

    // Result sink: random stalls, none in steady stretches, and a long
    // hold-off counted here once asked for.
    initial
    begin
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_seen)
            begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // APB write: setup then access; entered and left at a falling edge
    task automatic write_register(pidaw_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_config(q_t gp, q_t gi, q_t gd, q_t lo, q_t hi,
                               logic [pidaw_pkg::PERIOD_W-1:0] per, q_t sp);
        write_register(pidaw_pkg::REG_GAIN_P,   gp);
        write_register(pidaw_pkg::REG_GAIN_I,   gi);
        write_register(pidaw_pkg::REG_GAIN_D,   gd);
        write_register(pidaw_pkg::REG_LIMIT_LO, lo);
        write_register(pidaw_pkg::REG_LIMIT_HI, hi);
        write_register(pidaw_pkg::REG_PERIOD,   32'(per));
        write_register(pidaw_pkg::REG_SETPOINT, sp);
    endtask

    // One sample item, with random idle cycles ahead of it. valid stays high
    // on return so a following item goes out back to back.
    task automatic send_sample(logic func, q_t meas, q_t goal, logic goal_present,
                               logic [pidaw_pkg::TIME_W-1:0] now);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            smp.valid <= 1'b0;
            @(negedge clk);
        end
        smp.valid        <= 1'b1;
        smp.func         <= func;
        smp.measured     <= meas;
        smp.goal         <= goal;
        smp.goal_present <= goal_present;
        smp.now_ms       <= now;
        do @(posedge clk); while (!smp.ready);
        @(negedge clk);
    endtask

    // stop sending, wait for every expected drive, then let the pipe empty
    task automatic drain();
        smp.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly moderate values, a quarter over the full range
    function automatic q_t random_q(int shift);
        if ($urandom_range(0, 3) == 0)
            return q_t'($urandom);
        return q_t'($signed($urandom) >>> shift);
    endfunction

    task automatic random_config();
        q_t                             lo, hi;
        logic [pidaw_pkg::PERIOD_W-1:0] per;
        int                             r;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            lo = q_t'($signed($urandom) >>> 9);
            hi = lo + q_t'($urandom_range(0, 1 << 24));
        end
        else if (r < 8)
        begin
            lo = Q_MIN;
            hi = Q_MAX;
        end
        else
        begin
            // may cross
            lo = q_t'($urandom);
            hi = q_t'($urandom);
        end
        r = $urandom_range(0, 9);
        if (r < 6)
            per = pidaw_pkg::PERIOD_W'($urandom_range(1, 20));
        else if (r < 8)
            per = pidaw_pkg::PERIOD_W'($urandom_range(0, 65535));
        else if (r == 8)
            per = '0;
        else
            per = '1;
        load_config(random_q(13), random_q(13), random_q(13), lo, hi, per, random_q(8));
    endtask

    initial
    begin
        int r;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        smp.valid        = 1'b0;
        smp.func         = FUNC_NOW;
        smp.measured     = '0;
        smp.goal         = '0;
        smp.goal_present = 1'b0;
        smp.now_ms       = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed: gains 1.0 / 0.25 / 0.5, limits +-100.0, period 5, setpoint 3.0
        load_config(Q_ONE, Q_ONE / 4, Q_ONE / 2, -100 * Q_ONE, 100 * Q_ONE, 16'd5,
                    3 * Q_ONE);
        send_sample(FUNC_NOW,   '0,     '0,       1'b0, 32'd0);   // stored setpoint
        send_sample(FUNC_NOW,   Q_ONE,  2*Q_ONE,  1'b1, 32'd0);
        send_sample(FUNC_NOW,   Q_MAX,  Q_MIN,    1'b1, 32'd1);   // field extremes
        send_sample(FUNC_NOW,   Q_MIN,  Q_MAX,    1'b1, 32'd2);
        send_sample(FUNC_GATED, Q_ONE,  '0,       1'b0, 32'd4);   // too early, dropped
        send_sample(FUNC_GATED, Q_ONE/2,'0,       1'b0, 32'd5);   // exactly one period
        send_sample(FUNC_GATED, '0,     Q_ONE,    1'b1, 32'd9);   // dropped
        send_sample(FUNC_GATED, -Q_ONE, Q_ONE,    1'b1, 32'hFFFF_FFFE);
        send_sample(FUNC_GATED, '0,     '0,       1'b0, 32'd2);   // across wrap, short
        send_sample(FUNC_GATED, Q_ONE,  '0,       1'b0, 32'd3);   // across wrap, passes
        send_sample(FUNC_NOW,   '0,     '0,       1'b1, 32'hFFFF_FFFF); // leaves last time
        send_sample(FUNC_GATED, '0,     '0,       1'b0, 32'd7);   // still short of period
        // windup both ways: integral pinned at each limit
        send_sample(FUNC_NOW,   -Q_BIG, Q_BIG,    1'b1, 32'd8);
        send_sample(FUNC_NOW,   -Q_BIG, Q_BIG,    1'b1, 32'd8);
        send_sample(FUNC_NOW,   Q_BIG,  -Q_BIG,   1'b1, 32'd8);
        send_sample(FUNC_NOW,   Q_BIG,  -Q_BIG,   1'b1, 32'd8);
        drain();

        // crossed limits: every value ends at the high limit
        write_register(pidaw_pkg::REG_LIMIT_LO, 5 * Q_ONE);
        write_register(pidaw_pkg::REG_LIMIT_HI, -5 * Q_ONE);
        send_sample(FUNC_NOW, Q_ONE, -Q_ONE, 1'b1, 32'd8);
        send_sample(FUNC_NOW, -Q_BIG, Q_BIG, 1'b1, 32'd8);
        drain();

        // zero period: the gate always opens, even with no time passed
        write_register(pidaw_pkg::REG_PERIOD, 32'd0);
        send_sample(FUNC_GATED, Q_ONE, '0, 1'b0, 32'd7);
        send_sample(FUNC_GATED, Q_ONE, '0, 1'b0, 32'd7);
        drain();

        // extreme registers, longest period
        load_config(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, '1, Q_MIN);
        send_sample(FUNC_NOW,   Q_MAX, '0,    1'b0, 32'd100);
        send_sample(FUNC_NOW,   Q_MIN, Q_MAX, 1'b1, 32'd100);
        send_sample(FUNC_GATED, '0,    '0,    1'b0, 32'd100);              // dropped
        send_sample(FUNC_GATED, Q_ONE, '0,    1'b0, 32'(7 + 65535));        // passes
        send_sample(FUNC_GATED, '0,    '0,    1'b0, 32'(7 + 65535 + 65534));
        drain();

        // --- random phases, each with its own register setting
        clock_ms = $urandom;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            random_config();
            steady = (ph == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long sink hold-off while items keep coming: input must stall
                if (ph == 4 && n == 30)
                    hold_req = 1'b1;
                // sender pauses until everything is out
                if (ph == 6 && n == 100)
                    drain();
                r = $urandom_range(0, 9);
                if (r < 6)
                    clock_ms += $urandom_range(0, 12);
                else if (r < 9)
                    clock_ms += $urandom_range(0, 70000);
                else
                    clock_ms = $urandom;
                send_sample($urandom_range(0, 1) ? FUNC_GATED : FUNC_NOW,
                            random_q(8), random_q(8), 1'($urandom_range(0, 1)), clock_ms);
            end
            steady = 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
